@@ rtl/core/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg
// shared types and constants of the midtone stretch pixel core
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int PARAM_W   = 49;
  localparam int CFG_IDX_W = 4;
  localparam int NUM_W     = 44;
  localparam int DEN_W     = 40;
  localparam int REM_W     = 48;
  localparam int LANE_LAT  = 13;

  localparam logic [PARAM_W-1:0] PARAM_RESET = 49'h0_8000_FFFF_0000;
  localparam logic [7:0]         OUT_MAX     = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED   = 4'd0,
    REG_GREEN = 4'd1,
    REG_BLUE  = 4'd2,
    REG_MONO  = 4'd3
  } cfg_reg_t;

endpackage

@@ rtl/core/msp_pix_in_if.sv @@
// ----------------------------------------------------------------------------
// msp_pix_in_if
// pixel input channel: three raw samples
// ----------------------------------------------------------------------------
interface msp_pix_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_red;
  logic [15:0] sample_green;
  logic [15:0] sample_blue;

  modport source (output valid, sample_red, sample_green, sample_blue, input ready);
  modport sink   (input valid, sample_red, sample_green, sample_blue, output ready);
endinterface

@@ rtl/core/msp_pix_out_if.sv @@
// ----------------------------------------------------------------------------
// msp_pix_out_if
// pixel output channel: three display values
// ----------------------------------------------------------------------------
interface msp_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

@@ rtl/core/msp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// msp_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface msp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [48:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/msp_lane.sv @@
// ----------------------------------------------------------------------------
// msp_lane
// one color lane: clip, rational transfer curve and radix-2 divide pipeline
// ----------------------------------------------------------------------------
module msp_lane
  import msp_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        sample,
  input  logic [PARAM_W-1:0] params,
  output logic [7:0]         result
);

  localparam logic [15:0] MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

  logic [15:0] s, sh, hi;
  assign s  = sample & MASK;
  assign sh = params[15:0] & MASK;
  assign hi = params[31:16] & MASK;

  // stage 1: clip test and offsets
  logic [15:0] s1_x, s1_r;
  logic [16:0] s1_mid;
  logic        s1_fix;
  logic [7:0]  s1_fval;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x    <= s - sh;
      s1_r    <= hi - sh;
      s1_mid  <= params[48:32];
      s1_fix  <= (s < sh) || (s >= hi);
      s1_fval <= (s < sh) ? 8'd0 : OUT_MAX;
    end
  end

  // stage 2: products
  logic signed [17:0] k1;
  logic signed [18:0] k2;
  assign k1 = 18'sd65536 - $signed({1'b0, s1_mid});
  assign k2 = $signed({1'b0, s1_mid, 1'b0}) - 19'sd65536;

  logic signed [34:0] s2_a;
  logic [32:0]        s2_b;
  logic signed [35:0] s2_c;
  logic               s2_fix;
  logic [7:0]         s2_fval;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a    <= k1 * $signed({1'b0, s1_x});
      s2_b    <= s1_mid * s1_r;
      s2_c    <= k2 * $signed({1'b0, s1_x});
      s2_fix  <= s1_fix;
      s2_fval <= s1_fval;
    end
  end

  // stage 3: numerator is 255*a, denominator m*r - (2m-1)*x
  logic signed [NUM_W-1:0] a_ext;
  assign a_ext = NUM_W'(s2_a);

  logic signed [NUM_W-1:0] s3_num;
  logic signed [DEN_W-1:0] s3_den;
  logic                    s3_fix;
  logic [7:0]              s3_fval;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_num  <= (a_ext <<< 8) - a_ext;
      s3_den  <= $signed({7'b0, s2_b}) - DEN_W'(s2_c);
      s3_fix  <= s2_fix;
      s3_fval <= s2_fval;
    end
  end

  // stage 4: signs and magnitudes
  logic zero_q;
  assign zero_q = (s3_num == '0) || (s3_den == '0) || (s3_num[NUM_W-1] != s3_den[DEN_W-1]);

  logic [NUM_W-1:0] s4_n;
  logic [DEN_W-1:0] s4_d;
  logic             s4_fix;
  logic [7:0]       s4_fval;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_n    <= s3_num[NUM_W-1] ? NUM_W'(-s3_num) : NUM_W'(s3_num);
      s4_d    <= s3_den[DEN_W-1] ? DEN_W'(-s3_den) : DEN_W'(s3_den);
      s4_fix  <= s3_fix || zero_q;
      s4_fval <= s3_fix ? s3_fval : 8'd0;
    end
  end

  // stage 5: saturation when quotient would exceed 8 bits
  logic sat;
  assign sat = {4'b0, s4_n} >= {s4_d, 8'b0};

  logic [REM_W-1:0] rem  [0:8];
  logic [DEN_W-1:0] dv   [0:8];
  logic [7:0]       qv   [0:8];
  logic             fix  [0:8];
  logic [7:0]       fval [0:8];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {4'b0, s4_n};
      dv[0]   <= s4_d;
      qv[0]   <= 8'd0;
      fix[0]  <= s4_fix || sat;
      fval[0] <= s4_fix ? s4_fval : OUT_MAX;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < 8; k++) begin : g_div
    logic [REM_W-1:0] dk;
    logic             ge;
    assign dk = {8'b0, dv[k]} << (7 - k);
    assign ge = rem[k] >= dk;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? rem[k] - dk : rem[k];
        qv[k+1]   <= {qv[k][6:0], ge};
        dv[k+1]   <= dv[k];
        fix[k+1]  <= fix[k];
        fval[k+1] <= fval[k];
      end
    end
  end

  assign result = fix[8] ? fval[8] : qv[8];

endmodule

@@ rtl/core/midtone_stretch_pixel_core.sv @@
// ----------------------------------------------------------------------------
// midtone_stretch_pixel_core
// midtones transfer function display stretch, one pixel per clock
// ----------------------------------------------------------------------------
// pix_in carries three raw samples; pix_out carries three 8-bit display values.
// cfg writes a lane parameter word (shadow, highlight, midtone Q1.16) or the
// mono flag; write it only while no pixel is in flight. cfg is always ready.
// three identical lanes run side by side; the output stage merges them,
// copying the red lane to all outputs in mono mode.
// the 13 register stages of the lane pipeline (clip, products, sums,
// magnitudes, saturation check and an 8-stage one-bit-per-stage divider)
// carry each pixel from its input transfer to its output transfer.
// throughput: one pixel per clock while the receiver takes results.
// when the receiver stalls with a result waiting, the whole pipeline freezes,
// bubbles included, and pix_in.ready drops.
// reset: all pipeline stages empty, lanes at shadow 0, highlight 0xffff,
// midtone 0.5, mono off.
// ----------------------------------------------------------------------------
module midtone_stretch_pixel_core
  import msp_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input logic          clk,
  input logic          rst,
  msp_pix_in_if.sink   pix_in,
  msp_pix_out_if.source pix_out,
  msp_cfg_if.sink      cfg
);

  logic [PARAM_W-1:0] red_params, green_params, blue_params;
  logic               mono_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_params   <= PARAM_RESET;
      green_params <= PARAM_RESET;
      blue_params  <= PARAM_RESET;
      mono_mode    <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RED:   red_params   <= cfg.data;
        REG_GREEN: green_params <= cfg.data;
        REG_BLUE:  blue_params  <= cfg.data;
        REG_MONO:  mono_mode    <= cfg.data[0];
        default:   ;
      endcase
    end
  end

  logic [LANE_LAT-1:0] vld;
  logic                en;

  // advance unless a finished result is waiting on a stalled receiver
  assign en           = !vld[LANE_LAT-1] || pix_out.ready;
  assign pix_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LANE_LAT-2:0], pix_in.valid};
    end
  end

  logic [7:0] res_r, res_g, res_b;

  msp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_r (
    .clk(clk), .en(en), .sample(pix_in.sample_red), .params(red_params), .result(res_r)
  );
  msp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_g (
    .clk(clk), .en(en), .sample(pix_in.sample_green), .params(green_params), .result(res_g)
  );
  msp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_b (
    .clk(clk), .en(en), .sample(pix_in.sample_blue), .params(blue_params), .result(res_b)
  );

  // merge
  assign pix_out.valid     = vld[LANE_LAT-1];
  assign pix_out.out_red   = res_r;
  assign pix_out.out_green = mono_mode ? res_r : res_g;
  assign pix_out.out_blue  = mono_mode ? res_r : res_b;

  a_reset_empty: assert property (@(posedge clk) rst |=> !pix_out.valid)
    else $error("output valid right after reset");

  a_in_enters: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> vld[0])
    else $error("accepted pixel missing from first stage");

  a_mono_copy: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && mono_mode) |->
      (pix_out.out_green == pix_out.out_red) && (pix_out.out_blue == pix_out.out_red))
    else $error("mono outputs differ");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// checks the midtone stretch core: directed table, then random pixels under
// sender bursts and receiver stalls, compared with an integer stretch predictor
// ----------------------------------------------------------------------------
module tb_top;
  import msp_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [15:0] r, g, b;
  } pixel_t;
  typedef struct packed {
    logic [7:0] r, g, b;
  } disp_t;
  typedef struct {
    pixel_t pix;
    logic   known;
    disp_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;

  msp_pix_in_if  pix_in ();
  msp_pix_out_if pix_out ();
  msp_cfg_if     cfg ();

  midtone_stretch_pixel_core dut (
    .clk(clk), .rst(rst), .pix_in(pix_in), .pix_out(pix_out), .cfg(cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the lane registers
  logic [PARAM_W-1:0] lane_prm [3];
  logic               mono;

  disp_t pending_disp [$];
  int    errors = 0;
  int    sent = 0;
  int    got = 0;
  bit    stall_on = 1'b0;

  function automatic logic [7:0] stretch(logic [PARAM_W-1:0] p, logic [15:0] s);
    longint sh, hi, m, x, rng, num, den, q;
    sh  = p[15:0];
    hi  = p[31:16];
    m   = p[48:32];
    if (s < sh) return 8'd0;
    if (s >= hi) return OUT_MAX;
    x   = s - sh;
    rng = hi - sh;
    num = 255 * (65536 - m) * x;
    den = m * rng - (2 * m - 65536) * x;
    if (den == 0 || num == 0) return 8'd0;
    if ((num < 0) != (den < 0)) return 8'd0;
    if (num < 0) begin
      num = -num;
      den = -den;
    end
    q = num / den;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic disp_t predict(pixel_t px);
    disp_t d;
    d.r = stretch(lane_prm[0], px.r);
    d.g = mono ? d.r : stretch(lane_prm[1], px.g);
    d.b = mono ? d.r : stretch(lane_prm[2], px.b);
    return d;
  endfunction

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(cfg_reg_t idx, logic [PARAM_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == REG_MONO) mono = val[0];
    else if (idx <= REG_BLUE) lane_prm[idx] = val;
  endtask

  task automatic drain();
    while (pending_disp.size() != 0) @(posedge clk);
    repeat (LANE_LAT + 4) @(posedge clk);
  endtask

  task automatic send(pixel_t px, logic known, disp_t want);
    disp_t p;
    p = predict(px);
    if (known && p != want) begin
      errors++;
      if (errors <= 10) $display("table row %0d: predictor %h, table %h", sent, p, want);
    end
    pix_in.valid        <= 1'b1;
    pix_in.sample_red   <= px.r;
    pix_in.sample_green <= px.g;
    pix_in.sample_blue  <= px.b;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    pending_disp.push_back(known ? want : p);
    sent++;
  endtask

  task automatic gap();
    pix_in.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic logic [PARAM_W-1:0] rand_params();
    logic [15:0] a, b;
    logic [16:0] m;
    a = 16'($urandom);
    b = 16'($urandom);
    if ($urandom_range(0, 3) != 0 && a > b) {a, b} = {b, a};
    case ($urandom_range(0, 5))
      0: m = 17'd0;
      1: m = 17'h1FFFF;
      2: m = 17'h10000;
      default: m = 17'($urandom_range(1, 65535));
    endcase
    return {m, b, a};
  endfunction

  // receiver: stall pattern plus output check
  always @(posedge clk) begin
    disp_t d, w;
    cycles <= cycles + 1;
    if (!rst) begin
      if (pix_out.valid && pix_out.ready) begin
        d = {pix_out.out_red, pix_out.out_green, pix_out.out_blue};
        if (pending_disp.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer: %h", d);
        end else begin
          w = pending_disp.pop_front();
          got++;
          if (d.r !== w.r || d.g !== w.g || d.b !== w.b) begin
            errors++;
            if (errors <= 10) $display("pixel %0d: expected %h, got %h", got, w, d);
          end
        end
      end
      pix_out.ready <= stall_on ? ((cycles % 7) < 3 ? 1'b0 : 1'($urandom_range(0, 1)))
                                : 1'b1;
    end else begin
      pix_out.ready <= 1'b1;
    end
    if (cycles % 500 == 0) stall_on <= $urandom_range(0, 2) != 0;
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  row_t table_rows [$];

  initial begin
    pixel_t px;
    pix_in.valid = 1'b0;
    pix_in.sample_red = '0;
    pix_in.sample_green = '0;
    pix_in.sample_blue = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_RED;
    cfg.data = '0;
    for (int i = 0; i < 3; i++) lane_prm[i] = PARAM_RESET;
    mono = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset: 0 -> 0, full scale -> 255, midpoint at midtone 0.5 is linear
    table_rows = '{
      '{'{16'h0000, 16'hFFFF, 16'hFFFE}, 1'b1, '{8'd0, 8'd255, 8'd254}},
      '{'{16'h8000, 16'h0001, 16'h7FFF}, 1'b0, '0},
      '{'{16'h5555, 16'hAAAA, 16'h1234}, 1'b0, '0},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{8'd255, 8'd255, 8'd255}}
    };
    foreach (table_rows[i])
      send(table_rows[i].pix, table_rows[i].known, table_rows[i].want);
    pix_in.valid <= 1'b0;
    drain();

    // highlight not above shadow, midtone 0, midtone above 1
    write_reg(REG_RED,   {17'h00000, 16'h1000, 16'h2000});
    write_reg(REG_GREEN, {17'h00000, 16'hF000, 16'h0100});
    write_reg(REG_BLUE,  {17'h1FFFF, 16'hF000, 16'h0100});
    cfg.valid <= 1'b0;
    table_rows = '{
      '{'{16'h1FFF, 16'h0100, 16'h0100}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{16'h2000, 16'h0200, 16'h0200}, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{'{16'h3000, 16'h8000, 16'h8000}, 1'b0, '0},
      '{'{16'h0000, 16'hF000, 16'hEFFF}, 1'b1, '{8'd0, 8'd255, 8'd255}},
      '{'{16'hFFFF, 16'h00FF, 16'hFFFF}, 1'b1, '{8'd255, 8'd0, 8'd255}}
    };
    foreach (table_rows[i])
      send(table_rows[i].pix, table_rows[i].known, table_rows[i].want);
    pix_in.valid <= 1'b0;
    drain();

    // midtone exactly 1 and mono mode; out-of-range index is ignored
    write_reg(REG_RED, {17'h10000, 16'hFFFF, 16'h0000});
    write_reg(REG_MONO, 49'd1);
    write_reg(cfg_reg_t'(4'hF), 49'h1_2345_6789_ABCD);
    cfg.valid <= 1'b0;
    table_rows = '{
      '{'{16'h4000, 16'h0000, 16'hFFFF}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{'{16'hFFFF, 16'h0000, 16'h0000}, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{'{16'h0001, 16'hFFFF, 16'hFFFF}, 1'b0, '0}
    };
    foreach (table_rows[i])
      send(table_rows[i].pix, table_rows[i].known, table_rows[i].want);
    pix_in.valid <= 1'b0;
    drain();

    // random phases with fresh settings, bursts with gaps
    for (int ph = 0; ph < 11; ph++) begin
      write_reg(REG_RED, rand_params());
      write_reg(REG_GREEN, rand_params());
      write_reg(REG_BLUE, ph == 10 ? {17'h1FFFF, 16'hFFFF, 16'hFFFF} : rand_params());
      write_reg(REG_MONO, (ph % 3 == 2) ? 49'd1 : 49'd0);
      cfg.valid <= 1'b0;
      for (int n = 0; n < 100; ) begin
        int burst;
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst && n < 100; k++, n++) begin
          px.r = 16'($urandom);
          px.g = 16'($urandom);
          px.b = 16'($urandom);
          // bias samples toward the lane's active window
          if ($urandom_range(0, 1))
            px.r = 16'(lane_prm[0][15:0] + $urandom_range(0, 300));
          if ($urandom_range(0, 1))
            px.g = 16'(lane_prm[1][31:16] - $urandom_range(0, 300));
          send(px, 1'b0, '0);
        end
        if ($urandom_range(0, 2) == 0) gap();
        else if (n % 50 == 0) begin
          pix_in.valid <= 1'b0;
          while (pending_disp.size() != 0) @(posedge clk);
        end
      end
      pix_in.valid <= 1'b0;
      drain();
    end

    $display("%0d pixels sent, %0d display values checked over 14 register settings",
             sent, got);
    $display("covered shadow/highlight clipping, inverted levels, midtone 0, 1, above 1, mono");
    if (errors == 0 && pending_disp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_disp.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
